// File: rtl/ist_pkg.sv
`timescale 1ns / 1ps
// Shared types, opcodes and status codes for the ID set table.
package ist_pkg;

	localparam int IST_CAPACITY = 128;
	localparam int ID_W         = 32;

	typedef logic [ID_W-1:0] id_t;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_SEARCH = 3'd2;
	localparam logic [2:0] OP_UPDATE = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_RANGE    = 3'd4;

	// per-cell write controls, already qualified by the request outcome
	typedef struct packed {
		logic wr_key;   // append: take the request key
		logic shift;    // delete: take the right neighbor's value
		logic wr_new;   // update: take the replacement key
	} cell_ctl_t;

endpackage

// File: rtl/id_set_table_top.sv
`timescale 1ns / 1ps
// Top level of the ID set table: request/result streams, sequencer and the row of cells.
//
// Requests enter on s_axis: tuser carries the opcode, tdata the key, the
// replacement key and the read index. Each request gives exactly one result
// on m_axis: tuser carries the status, tdata the read data and entry count.
// An item has an accept cycle and a resolve cycle: in the accept cycle every cell
// compares its ID with the incoming key and registers the match; in the resolve
// cycle, which waits while a stalled result holds the output register, the
// prefix logic picks the first/last match, the cells append, shift or
// overwrite, and the result is loaded into the output register.
// No new item is accepted until the previous one has resolved.
// A finished result waits in the output register while the next item is
// accepted and compared; if the receiver still stalls, the second item holds
// in its resolve cycle and no further item is accepted.
// Reset empties the table (count zero) and clears both handshakes; stored
// IDs need no clearing since only entries below the count are ever read.
module id_set_table_top
	import ist_pkg::*;
#(
	parameter int CAPACITY = IST_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // key[31:0], new_key[63:32], read_index[70:64], zero pad
	input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // read_data[31:0], entry_count[39:32]
	output logic [2:0]  m_axis_tuser   // status[2:0]
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int XW = (CW > 7) ? CW : 8;

	logic          busy_q;
	logic          out_valid_q;
	logic [2:0]    op_q;
	id_t           key_q;
	id_t           nkey_q;
	logic [6:0]    ridx_q;
	logic [CW-1:0] count_q;
	logic [2:0]    status_q;
	id_t           rdata_q;

	logic          accept;
	logic          commit;
	id_t           vals  [0:CAPACITY-1];
	logic [CAPACITY-1:0] match;
	logic [CAPACITY-1:0] hit;
	logic [CAPACITY-1:0] first;
	logic [CAPACITY-1:0] ge_last;
	logic          any_hit;
	logic          full;
	logic          in_rng;
	logic [XW-1:0] ridx_x;
	logic          do_add;
	logic          do_del;
	logic          do_upd;
	logic [2:0]    status_d;
	id_t           rdata_d;

	assign s_axis_tready = ~busy_q;
	assign accept        = s_axis_tvalid & ~busy_q;
	assign commit        = busy_q & (~out_valid_q | m_axis_tready);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t ctl;
		assign hit[i]     = match[i] & (CW'(i) < count_q);
		assign ctl.wr_key = do_add & (CW'(i) == count_q);
		assign ctl.shift  = do_del & ge_last[i];
		assign ctl.wr_new = do_upd & first[i];

		ist_cell u_cell (
			.clk        (clk),
			.cmp_en     (accept),
			.cmp_key    (s_axis_tdata[31:0]),
			.ctl        (ctl),
			.add_key    (key_q),
			.new_key    (nkey_q),
			.next_value ((i == CAPACITY - 1) ? vals[i] : vals[(i+1) % CAPACITY]),
			.value      (vals[i]),
			.match      (match[i])
		);
	end

	ist_resolve #(
		.N (CAPACITY)
	) u_resolve (
		.hit     (hit),
		.first   (first),
		.ge_last (ge_last),
		.any     (any_hit)
	);

	assign full   = (count_q == CW'(CAPACITY));
	assign ridx_x = XW'(ridx_q);
	assign in_rng = ridx_x < XW'(count_q);

	always_comb begin
		do_add   = 1'b0;
		do_del   = 1'b0;
		do_upd   = 1'b0;
		status_d = ST_OK;
		rdata_d  = '0;
		case (op_q)
			OP_ADD: begin
				if (any_hit) begin
					status_d = ST_DUP;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					do_add = commit;
				end
			end
			OP_DELETE: begin
				if (any_hit) begin
					do_del = commit;
				end else begin
					status_d = ST_NOTFOUND;
				end
			end
			OP_SEARCH: begin
				if (!any_hit) begin
					status_d = ST_NOTFOUND;
				end
			end
			OP_UPDATE: begin
				if (any_hit) begin
					do_upd = commit;
				end else begin
					status_d = ST_NOTFOUND;
				end
			end
			OP_READ: begin
				if (in_rng) begin
					rdata_d = vals[ridx_x[IW-1:0]];
				end else begin
					status_d = ST_RANGE;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (do_add) begin
				count_q <= count_q + CW'(1);
			end else if (do_del) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_axis_tuser;
			key_q  <= s_axis_tdata[31:0];
			nkey_q <= s_axis_tdata[63:32];
			ridx_q <= s_axis_tdata[70:64];
		end
		if (commit) begin
			status_q <= status_d;
			rdata_q  <= rdata_d;
		end
	end

	logic [CW-1:0] count_out_q;

	always_ff @(posedge clk) begin
		if (commit) begin
			count_out_q <= do_add ? count_q + CW'(1) : (do_del ? count_q - CW'(1) : count_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {8'(count_out_q), rdata_q};

endmodule

// File: rtl/ist_cell.sv
`timescale 1ns / 1ps
// One table cell: holds an ID, compares it with the broadcast key, shifts from its neighbor.
module ist_cell
	import ist_pkg::*;
(
	input  logic      clk,
	input  logic      cmp_en,
	input  id_t       cmp_key,
	input  cell_ctl_t ctl,
	input  id_t       add_key,
	input  id_t       new_key,
	input  id_t       next_value,
	output id_t       value,
	output logic      match
);

	id_t  value_q;
	logic match_q;

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			match_q <= (value_q == cmp_key);
		end
		if (ctl.wr_key) begin
			value_q <= add_key;
		end else if (ctl.shift) begin
			value_q <= next_value;
		end else if (ctl.wr_new) begin
			value_q <= new_key;
		end
	end

	assign value = value_q;
	assign match = match_q;

endmodule

// File: rtl/ist_resolve.sv
`timescale 1ns / 1ps
// Match resolution: first match, at-or-after-last-match mask and any-match via log-depth prefix ORs.
module ist_resolve #(
	parameter int N = 128
) (
	input  logic [N-1:0] hit,
	output logic [N-1:0] first,
	output logic [N-1:0] ge_last,
	output logic         any
);

	localparam int L = (N > 1) ? $clog2(N) : 1;

	logic [N-1:0] pre [0:L];
	logic [N-1:0] suf [0:L];

	assign pre[0] = hit;
	assign suf[0] = hit;

	for (genvar k = 0; k < L; k++) begin : g_lvl
		for (genvar i = 0; i < N; i++) begin : g_bit
			if (i >= (1 << k)) begin : g_lo
				assign pre[k+1][i] = pre[k][i] | pre[k][i-(1<<k)];
			end else begin : g_lo0
				assign pre[k+1][i] = pre[k][i];
			end
			if (i + (1 << k) < N) begin : g_hi
				assign suf[k+1][i] = suf[k][i] | suf[k][i+(1<<k)];
			end else begin : g_hi0
				assign suf[k+1][i] = suf[k][i];
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_out
		if (i == 0) begin : g_first0
			assign first[i] = hit[i];
		end else begin : g_first
			assign first[i] = hit[i] & ~pre[L][i-1];
		end
		if (i == N - 1) begin : g_last0
			assign ge_last[i] = 1'b1;
		end else begin : g_last
			assign ge_last[i] = ~suf[L][i+1];
		end
	end

	assign any = pre[L][N-1];

endmodule
